// File: rtl/core/aup_pkg.sv
package aup_pkg;

    // Default sizes
    localparam int DEF_VALUE_BITS = 128;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed port widths
    localparam int OUT_VALUE_W = 128;
    localparam int OUT_HALF_W  = 64;
    localparam int OUT_COUNT_W = 16;
    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z    = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z    = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LC_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UC_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LC_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UC_B    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;

    // Radix values
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Parse control carried between top level and step logic
    typedef struct packed {
        phase_t            phase;
        logic [BASE_W-1:0] base;
    } parse_ctl_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    // Base-36 digit decode
    function automatic digit_t digit_decode(input logic [CHAR_W-1:0] c);
        digit_t d;
        d.ok  = 1'b0;
        d.val = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            d.val = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            d.ok  = 1'b1;
            d.val = DIGIT_W'(c - CH_LC_A) + DIGIT_W'(10);
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            d.ok  = 1'b1;
            d.val = DIGIT_W'(c - CH_UC_A) + DIGIT_W'(10);
        end
        return d;
    endfunction

    // C whitespace: space, TAB through CR
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// File: rtl/core/aup_step.sv
module aup_step #(
    parameter int VALUE_BITS = aup_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = aup_pkg::DEF_COUNT_BITS
) (
    input  logic [aup_pkg::CHAR_W-1:0] char_i,
    input  logic                       start_i,
    input  logic [aup_pkg::BASE_W-1:0] base_sel_i,
    input  aup_pkg::parse_ctl_t        ctl_i,
    input  logic [VALUE_BITS-1:0]      acc_i,
    input  logic [COUNT_BITS-1:0]      count_i,
    output aup_pkg::parse_ctl_t        ctl_o,
    output logic [VALUE_BITS-1:0]      acc_o,
    output logic [COUNT_BITS-1:0]      count_o,
    output logic                       emit_o
);
    import aup_pkg::*;

    parse_ctl_t          ctl_eff;
    logic [VALUE_BITS-1:0] acc_eff;
    logic [COUNT_BITS-1:0] cnt_eff;
    digit_t              dig;
    logic                sp;
    logic [BASE_W-1:0]   use_base;
    logic                try_digit;
    logic                bump;
    logic                mac;
    logic [VALUE_BITS-1:0] prod;

    // Start clears the parse state and latches the selected base
    always_comb begin
        ctl_eff.phase = start_i ? PH_SKIP : ctl_i.phase;
        ctl_eff.base  = start_i ? base_sel_i : ctl_i.base;
        acc_eff       = start_i ? '0 : acc_i;
        cnt_eff       = start_i ? '0 : count_i;
        dig           = digit_decode(char_i);
        sp            = is_space(char_i);
    end

    // Next phase / base
    always_comb begin
        ctl_o     = ctl_eff;
        use_base  = ctl_eff.base;
        try_digit = 1'b0;
        bump      = 1'b0;
        mac       = 1'b0;
        emit_o    = 1'b0;
        case (ctl_eff.phase)
            PH_SKIP: begin
                if (sp) begin
                    bump = 1'b1;
                end else if (ctl_eff.base == BASE_AUTO && char_i == CH_ZERO) begin
                    bump        = 1'b1;
                    ctl_o.phase = PH_ZERO;
                end else begin
                    use_base  = (ctl_eff.base == BASE_AUTO) ? BASE_DEC : ctl_eff.base;
                    try_digit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (char_i == CH_LC_X || char_i == CH_UC_X) begin
                    bump        = 1'b1;
                    ctl_o.base  = BASE_HEX;
                    ctl_o.phase = PH_DIGITS;
                end else if (char_i == CH_LC_B || char_i == CH_UC_B) begin
                    bump        = 1'b1;
                    ctl_o.base  = BASE_BIN;
                    ctl_o.phase = PH_DIGITS;
                end else begin
                    use_base  = BASE_OCT;
                    try_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                try_digit = 1'b1;
            end
            default: begin
            end
        endcase
        if (try_digit) begin
            ctl_o.base = use_base;
            if (dig.ok && (BASE_W'(dig.val) < use_base)) begin
                bump        = 1'b1;
                mac         = 1'b1;
                ctl_o.phase = PH_DIGITS;
            end else begin
                emit_o      = 1'b1;
                ctl_o.phase = PH_DONE;
            end
        end
    end

    // acc*base + digit, wrapping at the accumulator width
    assign prod = acc_eff * VALUE_BITS'(use_base) + VALUE_BITS'(dig.val);

    always_comb begin
        acc_o   = mac ? prod : acc_eff;
        count_o = (bump && cnt_eff != {COUNT_BITS{1'b1}}) ? cnt_eff + 1'b1 : cnt_eff;
    end

endmodule

// File: rtl/core/ascii_unsigned_integer_parser_top.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------------
// s_       | in        | s_valid / s_ready  | s_char_code[7:0], s_start_req
// m_       | out       | m_valid / m_ready  | m_value_low[63:0], m_value_high[63:0],
//          |           |                    | m_consumed_count[15:0]
// cfg_     | in        | cfg_wr_en          | cfg_wr_data[5:0] (base_select)
//
// One item per cycle sustained while the output register is empty or being read: each item
// sits in the input register while the parse step (one accumulator multiply-add by the base) runs.
// A terminating item passes through the input register and then the output register to m_valid.
// The step stalls only while a finished result waits in the output register.
// aresetn is synchronous, active low; it clears the parse state to "skipping
// whitespace, automatic base, zero value, zero count" and base_select to 0.
module ascii_unsigned_integer_parser_top #(
    parameter int VALUE_BITS = aup_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = aup_pkg::DEF_COUNT_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [aup_pkg::BASE_W-1:0]      cfg_wr_data,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [aup_pkg::CHAR_W-1:0]      s_char_code,
    input  logic                            s_start_req,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [aup_pkg::OUT_HALF_W-1:0]  m_value_low,
    output logic [aup_pkg::OUT_HALF_W-1:0]  m_value_high,
    output logic [aup_pkg::OUT_COUNT_W-1:0] m_consumed_count
);
    import aup_pkg::*;

    // base_select register
    logic [BASE_W-1:0]     base_sel_reg;

    // input register
    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [CHAR_W-1:0]     in_char_reg;
    logic                  in_start_reg;

    // parse state
    parse_ctl_t            ctl_reg;
    parse_ctl_t            ctl_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  emit;

    // output register
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic [OUT_VALUE_W-1:0] out_value_wide;

    logic                  step_fire;
    logic                  s_fire;

    // The step runs whenever an item is held and the output register can take a result
    assign step_fire = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    aup_step #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .char_i     (in_char_reg),
        .start_i    (in_start_reg),
        .base_sel_i (base_sel_reg),
        .ctl_i      (ctl_reg),
        .acc_i      (acc_reg),
        .count_i    (cnt_reg),
        .ctl_o      (ctl_next),
        .acc_o      (acc_next),
        .count_o    (cnt_next),
        .emit_o     (emit)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (step_fire) begin
            in_vld_next = 1'b0;
        end
        if (s_fire) begin
            in_vld_next = 1'b1;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (step_fire && emit) begin
            out_vld_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_sel_reg  <= BASE_AUTO;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            ctl_reg.phase <= PH_SKIP;
            ctl_reg.base  <= BASE_AUTO;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_sel_reg <= cfg_wr_data;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (step_fire) begin
                ctl_reg <= ctl_next;
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // payload registers; on a terminator the step leaves value and count unchanged
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg  <= s_char_code;
            in_start_reg <= s_start_req;
        end
        if (step_fire && emit) begin
            out_value_reg <= acc_next;
            out_count_reg <= OUT_COUNT_W'(cnt_next);
        end
    end

    assign out_value_wide   = OUT_VALUE_W'(out_value_reg);
    assign m_valid          = out_vld_reg;
    assign m_value_low      = out_value_wide[OUT_HALF_W-1:0];
    assign m_value_high     = out_value_wide[OUT_VALUE_W-1:OUT_HALF_W];
    assign m_consumed_count = out_count_reg;

endmodule
